// ===== rtl/dcdm_pkg.sv =====
// shared types and constants for the differential curve drive mixer
`default_nettype none
package dcdm_pkg;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int LN_DEPTH_DEF   = 256;
    localparam int SENS_W         = 16;
    localparam logic [SENS_W-1:0] SENS_RESET = 16'd12288;
    localparam logic [15:0]       LN2_Q16    = 16'd45426;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } t_side;

    typedef struct packed {
        t_side side;
        logic  rd_zero;
        logic  rn_zero;
        logic  neg;
    } t_ctrl;
endpackage
`default_nettype wire

// ===== rtl/dcdm_ln.sv =====
// log stages: magnitude of the curve, normalisation and log2 table lookup
`default_nettype none
module dcdm_ln #(
    parameter int DATA_WIDTH     = dcdm_pkg::DATA_WIDTH_DEF,
    parameter int LN_TABLE_DEPTH = dcdm_pkg::LN_DEPTH_DEF,
    localparam int EW = $clog2(DATA_WIDTH),
    localparam int MW = EW + 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire signed [DATA_WIDTH-1:0]  i_mag,
    input  wire signed [DATA_WIDTH-1:0]  i_cur,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic signed [DATA_WIDTH-1:0] o_mag,
    output dcdm_pkg::t_side              o_side,
    output logic [MW-1:0]                o_mlg
);
    localparam int F  = DATA_WIDTH - 1;
    localparam int IW = $clog2(LN_TABLE_DEPTH);

    typedef logic [15:0] t_rom [LN_TABLE_DEPTH];

    function automatic t_rom build_rom();
        t_rom             rom;
        longint unsigned  y;
        logic [15:0]      r;
        for (int k = 0; k < LN_TABLE_DEPTH; k++) begin
            y = ((longint'(LN_TABLE_DEPTH) + longint'(k)) << 30) / LN_TABLE_DEPTH;
            r = '0;
            for (int b = 0; b < 16; b++) begin
                y = (y * y) >> 30;
                r = {r[14:0], 1'b0};
                if (y >= (64'd1 << 31)) begin
                    r[0] = 1'b1;
                    y = y >> 1;
                end
            end
            rom[k] = r;
        end
        return rom;
    endfunction

    localparam t_rom LN_ROM = build_rom();

    logic                         r1_v, r2_v, r3_v;
    logic signed [DATA_WIDTH-1:0] r1_mag, r2_mag, r3_mag;
    dcdm_pkg::t_side              r1_side, r2_side, r3_side;
    logic [DATA_WIDTH-1:0]        r1_a;
    logic [EW-1:0]                r2_sh;
    logic [IW-1:0]                r2_idx;
    logic [MW-1:0]                r3_mlg;
    logic                         en1, en2, en3;

    logic [DATA_WIDTH-1:0] n_a;
    dcdm_pkg::t_side       n_side;
    logic [EW-1:0]         n_e, n_sh;
    logic [DATA_WIDTH-1:0] n_norm;
    logic [F+IW:0]         n_pr;
    logic [MW-1:0]         n_mlg;

    assign en3     = !r3_v || i_ready;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign o_ready = en1;

    always_comb begin
        n_a = i_cur[DATA_WIDTH-1] ? DATA_WIDTH'(-i_cur) : DATA_WIDTH'(i_cur);
        if (i_cur[DATA_WIDTH-1]) begin
            n_side = dcdm_pkg::SIDE_LEFT;
        end else if (i_cur != '0) begin
            n_side = dcdm_pkg::SIDE_RIGHT;
        end else begin
            n_side = dcdm_pkg::SIDE_NONE;
        end
    end

    always_comb begin
        n_e = '0;
        for (int i = 0; i < DATA_WIDTH; i++) begin
            if (r1_a[i]) begin
                n_e = EW'(i);
            end
        end
        n_sh   = EW'(F) - n_e;
        n_norm = r1_a << n_sh;
        n_pr   = (F+IW+1)'(n_norm[F-1:0]) * (F+IW+1)'(LN_TABLE_DEPTH);
        n_mlg  = {r2_sh, 16'b0} - MW'(LN_ROM[r2_idx]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_mag  <= i_mag;
            r1_side <= n_side;
            r1_a    <= n_a;
        end
        if (en2) begin
            r2_mag  <= r1_mag;
            r2_side <= r1_side;
            r2_sh   <= n_sh;
            r2_idx  <= n_pr[F+IW-1:F];
        end
        if (en3) begin
            r3_mag  <= r2_mag;
            r3_side <= r2_side;
            r3_mlg  <= n_mlg;
        end
    end

    assign o_valid = r3_v;
    assign o_mag   = r3_mag;
    assign o_side  = r3_side;
    assign o_mlg   = r3_mlg;
endmodule
`default_nettype wire

// ===== rtl/dcdm_ratio.sv =====
// ratio stages: natural log, numerator and denominator terms, numerator product
`default_nettype none
module dcdm_ratio #(
    parameter int DATA_WIDTH = dcdm_pkg::DATA_WIDTH_DEF,
    localparam int EW = $clog2(DATA_WIDTH),
    localparam int MW = EW + 16,
    localparam int VW = EW + 17
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire [dcdm_pkg::SENS_W-1:0]       i_sens,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire signed [DATA_WIDTH-1:0]      i_mag,
    input  dcdm_pkg::t_side                  i_side,
    input  wire [MW-1:0]                     i_mlg,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic signed [DATA_WIDTH-1:0]     o_mag,
    output dcdm_pkg::t_ctrl                  o_ctrl,
    output logic signed [DATA_WIDTH+VW-1:0]  o_num,
    output logic [VW-1:0]                    o_den
);
    localparam int NW = DATA_WIDTH + VW;

    logic                         r1_v, r2_v, r3_v;
    logic signed [DATA_WIDTH-1:0] r1_mag, r2_mag, r3_mag;
    dcdm_pkg::t_side              r1_side, r2_side;
    logic [MW+15:0]               r1_prod;
    logic signed [VW-1:0]         r2_rd, r2_rn;
    dcdm_pkg::t_ctrl              r3_ctrl;
    logic signed [NW-1:0]         r3_num;
    logic [VW-1:0]                r3_den;
    logic                         en1, en2, en3;

    logic [MW+15:0]       n_rnd;
    logic signed [VW-1:0] n_v, n_s, n_rd, n_rn;
    dcdm_pkg::t_ctrl      n_ctrl;

    assign en3     = !r3_v || i_ready;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign o_ready = en1;

    always_comb begin
        n_rnd = r1_prod + (MW+16)'(1 << 17);
        n_v   = -$signed(VW'(n_rnd[MW+15:18]));
        n_s   = $signed(VW'(i_sens));
        n_rd  = n_v + n_s;
        n_rn  = n_v - n_s;
        n_ctrl.side    = r2_side;
        n_ctrl.rd_zero = (r2_rd == '0);
        n_ctrl.rn_zero = (r2_rn == '0);
        n_ctrl.neg     = r2_mag[DATA_WIDTH-1] ^ r2_rd[VW-1] ^ r2_rn[VW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_mag  <= i_mag;
            r1_side <= i_side;
            r1_prod <= (MW+16)'(i_mlg) * (MW+16)'(dcdm_pkg::LN2_Q16);
        end
        if (en2) begin
            r2_mag  <= r1_mag;
            r2_side <= r1_side;
            r2_rd   <= n_rd;
            r2_rn   <= n_rn;
        end
        if (en3) begin
            r3_mag  <= r2_mag;
            r3_ctrl <= n_ctrl;
            r3_num  <= NW'(r2_mag) * NW'(r2_rd);
            r3_den  <= r2_rn[VW-1] ? VW'(-r2_rn) : VW'(r2_rn);
        end
    end

    assign o_valid = r3_v;
    assign o_mag   = r3_mag;
    assign o_ctrl  = r3_ctrl;
    assign o_num   = r3_num;
    assign o_den   = r3_den;
endmodule
`default_nettype wire

// ===== rtl/dcdm_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow stage
`default_nettype none
module dcdm_div #(
    parameter int DATA_WIDTH = dcdm_pkg::DATA_WIDTH_DEF,
    localparam int EW = $clog2(DATA_WIDTH),
    localparam int VW = EW + 17
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire signed [DATA_WIDTH-1:0]      i_mag,
    input  dcdm_pkg::t_ctrl                  i_ctrl,
    input  wire signed [DATA_WIDTH+VW-1:0]   i_num,
    input  wire [VW-1:0]                     i_den,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic signed [DATA_WIDTH-1:0]     o_mag,
    output dcdm_pkg::t_ctrl                  o_ctrl,
    output logic                             o_ovf,
    output logic [DATA_WIDTH-1:0]            o_quo
);
    localparam int NW = DATA_WIDTH + VW;
    localparam int NS = DATA_WIDTH + 1;

    logic                         r_v   [NS];
    logic [NW-1:0]                r_rem [NS];
    logic [VW-1:0]                r_den [NS];
    logic [DATA_WIDTH-1:0]        r_q   [NS];
    logic signed [DATA_WIDTH-1:0] r_mag [NS];
    dcdm_pkg::t_ctrl              r_ctrl[NS];
    logic                         r_ovf [NS];
    logic                         en    [NS];

    logic [NW-1:0] n_abs;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int j = NS-2; j >= 0; j--) begin
            en[j] = !r_v[j] || en[j+1];
        end
    end

    assign o_ready = en[0];
    assign n_abs   = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rem[0]  <= n_abs;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_mag[0]  <= i_mag;
            r_ctrl[0] <= i_ctrl;
            r_ovf[0]  <= (n_abs >= (NW'(i_den) << DATA_WIDTH));
        end
    end

    for (genvar j = 1; j < NS; j++) begin : g_bit
        localparam int K = DATA_WIDTH - j;
        logic [NW-1:0] n_sub;
        logic          n_ge;

        assign n_sub = NW'(r_den[j-1]) << K;
        assign n_ge  = (r_rem[j-1] >= n_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (en[j]) begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[j]) begin
                r_rem[j]  <= n_ge ? r_rem[j-1] - n_sub : r_rem[j-1];
                r_den[j]  <= r_den[j-1];
                r_q[j]    <= r_q[j-1] | (DATA_WIDTH'(n_ge) << K);
                r_mag[j]  <= r_mag[j-1];
                r_ctrl[j] <= r_ctrl[j-1];
                r_ovf[j]  <= r_ovf[j-1];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_mag   = r_mag[NS-1];
    assign o_ctrl  = r_ctrl[NS-1];
    assign o_ovf   = r_ovf[NS-1];
    assign o_quo   = r_q[NS-1];
endmodule
`default_nettype wire

// ===== rtl/differential_curve_drive_mixer_top.sv =====
// top level of the differential curve drive mixer
// Usage: an input item (speed magnitude and turn curve, signed Q1.15) is
// offered on i_valid/o_ready; one result item (left and right drive levels)
// comes back on o_valid/i_ready for every accepted item, in order.
// The user must write the sensitivity register through i_cfg_wr_en/i_cfg_wr_data
// only while the block is idle; the block itself does not enforce this. Reset loads 0.75 (Q2.14).
// The pipeline has DATA_WIDTH + 8 register stages: three log stages, three
// ratio stages, DATA_WIDTH + 1 divider stages (an overflow check, then one
// quotient bit per stage) and the output register.
// Throughput is one item per cycle while the receiver keeps i_ready high;
// every stage holds its own valid bit.
// When the receiver stalls, items fill empty stages behind the waiting result,
// and o_ready falls only once the whole pipeline is full. Nothing is dropped
// or repeated.
// Reset (synchronous, active low) empties all stages and restores the
// sensitivity; the log table is constant logic and needs no fill.
`default_nettype none
module differential_curve_drive_mixer_top #(
    parameter int DATA_WIDTH     = dcdm_pkg::DATA_WIDTH_DEF,
    parameter int LN_TABLE_DEPTH = dcdm_pkg::LN_DEPTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wr_en,
    input  wire [dcdm_pkg::SENS_W-1:0]       i_cfg_wr_data,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire signed [DATA_WIDTH-1:0]      i_speed_magnitude,
    input  wire signed [DATA_WIDTH-1:0]      i_turn_curve,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic signed [DATA_WIDTH-1:0]     o_left_drive,
    output logic signed [DATA_WIDTH-1:0]     o_right_drive
);
    localparam int EW = $clog2(DATA_WIDTH);
    localparam int MW = EW + 16;
    localparam int VW = EW + 17;
    localparam logic signed [DATA_WIDTH-1:0] LVL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] LVL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [dcdm_pkg::SENS_W-1:0] r_sens;

    logic                         ln_valid, ln_ready;
    logic signed [DATA_WIDTH-1:0] ln_mag;
    dcdm_pkg::t_side              ln_side;
    logic [MW-1:0]                ln_mlg;

    logic                           ra_valid, ra_ready;
    logic signed [DATA_WIDTH-1:0]   ra_mag;
    dcdm_pkg::t_ctrl                ra_ctrl;
    logic signed [DATA_WIDTH+VW-1:0] ra_num;
    logic [VW-1:0]                  ra_den;

    logic                         dv_valid, dv_ready;
    logic signed [DATA_WIDTH-1:0] dv_mag;
    dcdm_pkg::t_ctrl              dv_ctrl;
    logic                         dv_ovf;
    logic [DATA_WIDTH-1:0]        dv_quo;

    logic                         r_out_v;
    logic                         r_straight;
    logic signed [DATA_WIDTH-1:0] r_left, r_right;

    logic signed [DATA_WIDTH:0]   n_qs;
    logic signed [DATA_WIDTH-1:0] n_in, n_left, n_right, n_rneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens <= dcdm_pkg::SENS_RESET;
        end else if (i_cfg_wr_en) begin
            r_sens <= i_cfg_wr_data;
        end
    end

    dcdm_ln #(
        .DATA_WIDTH     (DATA_WIDTH),
        .LN_TABLE_DEPTH (LN_TABLE_DEPTH)
    ) u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mag   (i_speed_magnitude),
        .i_cur   (i_turn_curve),
        .o_valid (ln_valid),
        .i_ready (ln_ready),
        .o_mag   (ln_mag),
        .o_side  (ln_side),
        .o_mlg   (ln_mlg)
    );

    dcdm_ratio #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sens  (r_sens),
        .i_valid (ln_valid),
        .o_ready (ln_ready),
        .i_mag   (ln_mag),
        .i_side  (ln_side),
        .i_mlg   (ln_mlg),
        .o_valid (ra_valid),
        .i_ready (ra_ready),
        .o_mag   (ra_mag),
        .o_ctrl  (ra_ctrl),
        .o_num   (ra_num),
        .o_den   (ra_den)
    );

    dcdm_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ra_valid),
        .o_ready (ra_ready),
        .i_mag   (ra_mag),
        .i_ctrl  (ra_ctrl),
        .i_num   (ra_num),
        .i_den   (ra_den),
        .o_valid (dv_valid),
        .i_ready (dv_ready),
        .o_mag   (dv_mag),
        .o_ctrl  (dv_ctrl),
        .o_ovf   (dv_ovf),
        .o_quo   (dv_quo)
    );

    assign dv_ready = !r_out_v || i_ready;

    always_comb begin
        n_qs = dv_ctrl.neg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
        if (dv_ctrl.rd_zero) begin
            n_in = '0;
        end else if (dv_ctrl.rn_zero) begin
            if (dv_mag[DATA_WIDTH-1]) begin
                n_in = LVL_MIN;
            end else if (dv_mag != '0) begin
                n_in = LVL_MAX;
            end else begin
                n_in = '0;
            end
        end else if (dv_ovf) begin
            n_in = dv_ctrl.neg ? LVL_MIN : LVL_MAX;
        end else if (n_qs > $signed({LVL_MAX[DATA_WIDTH-1], LVL_MAX})) begin
            n_in = LVL_MAX;
        end else if (n_qs < $signed({LVL_MIN[DATA_WIDTH-1], LVL_MIN})) begin
            n_in = LVL_MIN;
        end else begin
            n_in = n_qs[DATA_WIDTH-1:0];
        end
        n_left  = (dv_ctrl.side == dcdm_pkg::SIDE_LEFT)  ? n_in : dv_mag;
        n_right = (dv_ctrl.side == dcdm_pkg::SIDE_RIGHT) ? n_in : dv_mag;
        n_rneg  = (n_right == LVL_MIN) ? LVL_MAX : -n_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (dv_ready) begin
            r_out_v <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_ready) begin
            r_left     <= n_left;
            r_right    <= n_rneg;
            r_straight <= (dv_ctrl.side == dcdm_pkg::SIDE_NONE);
        end
    end

    assign o_valid       = r_out_v;
    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;

    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_v |-> o_ready)
        else $error("input stalled with empty output register");

    a_straight_mirror : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_straight && r_left != LVL_MIN) |-> (r_right == -r_left))
        else $error("straight item drives wheels unequally");

    a_empty_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present right after reset");
endmodule
`default_nettype wire
